/* rtl/scalar_kalman_filter_unit_assert.svh */
// Assertion macros used by the checker of the Kalman filter unit.
`ifndef SCALAR_KALMAN_FILTER_UNIT_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SKF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("skf assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define SKF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("skf assertion failed");

`endif

/* rtl/skf_pkg.sv */
`timescale 1ns / 1ps
package skf_pkg;

  localparam int EST_W     = 32;  // estimate and variance width
  localparam int CFG_W     = 32;  // configuration register width
  localparam int CFG_IDX_W = 1;
  localparam int GAIN_BITS = 16;  // fraction bits of the gain
  localparam int GAIN_W    = GAIN_BITS + 1;
  localparam int DEN_W     = EST_W + 1;
  localparam int REM_W     = EST_W + 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROCESS_NOISE     = 1'b0,
    CFG_MEASUREMENT_NOISE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } skf_state_e;

  typedef logic signed [EST_W-1:0] est_t;
  typedef logic [EST_W-1:0]        var_t;
  typedef logic [GAIN_W-1:0]       gain_t;

endpackage

/* rtl/skf_if.sv */
`timescale 1ns / 1ps
interface skf_meas_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered_estimate;
  logic [16:0]        kalman_gain;

  modport source (output valid, output filtered_estimate, output kalman_gain, input ready);
  modport sink   (input valid, input filtered_estimate, input kalman_gain, output ready);
endinterface

/* rtl/scalar_kalman_filter_unit.sv */
`timescale 1ns / 1ps
// One-dimensional Kalman filter on signed samples, estimate and variance held in
// Q(32-FRAC_BITS).FRAC_BITS, gain in Q1.16. One sample is in flight at a time: an item
// passes through the bit-serial gain divider, a load of the two bit-serial multipliers
// that update estimate and variance side by side, the multiplier steps, a check that both
// have finished and a round-and-commit step; the next sample can be taken in the same
// cycle as the result appears. The result sits in an output register, so the next sample
// is taken while it waits; a result that is still not taken when the next one is ready
// stalls that next one. Q and R are to be written through the configuration port while
// the unit is idle; the unit does not enforce this. The one-bit index selects Q or R.
module scalar_kalman_filter_unit
  import skf_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  skf_meas_if.sink             meas_i,
  skf_result_if.source         result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int ZW = (SAMPLE_WIDTH + FRAC_BITS > EST_W + 1) ?
                      SAMPLE_WIDTH + FRAC_BITS : EST_W + 1;
  localparam int PW = DEN_W + GAIN_W;

  localparam var_t Q_RESET   = EST_W'(64'd20 << FRAC_BITS);
  localparam var_t R_RESET   = EST_W'(64'd200 << FRAC_BITS);
  localparam var_t VAR_RESET = EST_W'(64'd1 << FRAC_BITS);
  localparam logic signed [ZW-1:0] Z_MAX = ZW'({1'b0, {(EST_W-1){1'b1}}});
  localparam logic signed [ZW-1:0] Z_MIN = ~Z_MAX;
  localparam logic signed [PW-1:0] HALF  = PW'(1) <<< (GAIN_BITS - 1);
  localparam logic signed [EST_W+1:0] X_MAX = (EST_W+2)'({1'b0, {(EST_W-1){1'b1}}});
  localparam logic signed [EST_W+1:0] X_MIN = ~X_MAX;

  skf_state_e state_q, state_d;

  var_t  q_noise_q, r_noise_q;
  est_t  est_q, est_d;
  var_t  var_q, var_d;
  var_t  pm_q;
  logic [DEN_W-1:0] sum_q;
  logic signed [EST_W:0] diff_q;
  gain_t gain_q, gain_d;

  logic                  out_valid_q, out_valid_d;
  est_t                  out_est_q, out_est_d;
  gain_t                 out_gain_q, out_gain_d;

  logic                  accept;
  logic [EST_W:0]        pm_wide;
  var_t                  pm;
  logic [DEN_W-1:0]      sum;
  logic signed [ZW-1:0]  z_full;
  est_t                  z;
  logic signed [EST_W:0] diff;

  logic                  div_done;
  gain_t                 div_quot;
  logic                  mul_done;
  logic                  mul_var_done;
  logic signed [PW-1:0]  prod_est;
  logic signed [PW-1:0]  prod_var;
  logic signed [PW-1:0]  rounded;
  logic signed [EST_W+1:0] x_new;
  logic                  can_load;

  // Operand preparation at acceptance.
  always_comb begin
    pm_wide = {1'b0, var_q} + {1'b0, q_noise_q};
    pm      = pm_wide[EST_W] ? '1 : pm_wide[EST_W-1:0];
    sum     = {1'b0, pm} + {1'b0, r_noise_q};
    z_full  = ZW'(meas_i.measurement) <<< FRAC_BITS;
    if (z_full > Z_MAX)      z = est_t'(Z_MAX[EST_W-1:0]);
    else if (z_full < Z_MIN) z = est_t'(Z_MIN[EST_W-1:0]);
    else                     z = est_t'(z_full[EST_W-1:0]);
    diff    = {z[EST_W-1], z} - {est_q[EST_W-1], est_q};
  end

  assign meas_i.ready = (state_q == ST_IDLE);
  assign accept       = meas_i.valid && meas_i.ready;

  skf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .num_i   (pm),
    .den_i   (sum),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  // Zero denominator forces a zero gain.
  assign gain_d = (sum_q == '0) ? '0 : div_quot;

  skf_mul #(.AW(DEN_W)) u_mul_est (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_done),
    .mcand_i (diff_q),
    .mplier_i(gain_d),
    .prod_o  (prod_est),
    .done_o  (mul_done)
  );

  skf_mul #(.AW(DEN_W)) u_mul_var (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_done),
    .mcand_i ({1'b0, pm_q}),
    .mplier_i(GAIN_ONE - gain_d),
    .prod_o  (prod_var),
    .done_o  (mul_var_done)
  );

  // Round the step to nearest, halves up, then add to the old estimate.
  always_comb begin
    rounded = prod_est + HALF;
    x_new   = {{2{est_q[EST_W-1]}}, est_q} + (EST_W+2)'(rounded[PW-1:GAIN_BITS]);
  end

  assign can_load = !out_valid_q || result_o.ready;

  always_comb begin
    state_d     = state_q;
    est_d       = est_q;
    var_d       = var_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_est_d   = out_est_q;
    out_gain_d  = out_gain_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_MUL;
      ST_MUL:  if (mul_done && mul_var_done) state_d = ST_FIN;
      ST_FIN: begin
        if (can_load) begin
          if (x_new > X_MAX)      est_d = est_t'(X_MAX[EST_W-1:0]);
          else if (x_new < X_MIN) est_d = est_t'(X_MIN[EST_W-1:0]);
          else                    est_d = est_t'(x_new[EST_W-1:0]);
          var_d       = prod_var[EST_W+GAIN_BITS-1:GAIN_BITS];
          out_valid_d = 1'b1;
          out_est_d   = est_d;
          out_gain_d  = gain_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      q_noise_q   <= Q_RESET;
      r_noise_q   <= R_RESET;
      est_q       <= '0;
      var_q       <= VAR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      est_q       <= est_d;
      var_q       <= var_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PROCESS_NOISE:     q_noise_q <= cfg_data_i;
          CFG_MEASUREMENT_NOISE: r_noise_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pm_q   <= pm;
      sum_q  <= sum;
      diff_q <= diff;
    end
    if (div_done) gain_q <= gain_d;
    out_est_q  <= out_est_d;
    out_gain_q <= out_gain_d;
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.filtered_estimate = out_est_q;
  assign result_o.kalman_gain       = out_gain_q;

endmodule

/* rtl/skf_div.sv */
`timescale 1ns / 1ps
// Restoring radix-2 divider: quotient = floor(num * 2^GAIN_BITS / den), num <= den.
module skf_div
  import skf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  var_t             num_i,
  input  logic [DEN_W-1:0] den_i,
  output gain_t            quot_o,
  output logic             done_o
);

  localparam int CNT_W = $clog2(GAIN_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(GAIN_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  gain_t            quot_q, quot_d;

  logic [REM_W:0]   diff;
  logic             ge;
  logic [REM_W-1:0] rem_sub;

  always_comb begin
    diff    = {1'b0, rem_q} - (REM_W + 1)'(den_q);
    ge      = ~diff[REM_W];
    rem_sub = ge ? diff[REM_W-1:0] : rem_q;

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = REM_W'(num_i);
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      quot_d = {quot_q[GAIN_W-2:0], ge};
      rem_d  = {rem_sub[REM_W-2:0], 1'b0};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

/* rtl/skf_mul.sv */
`timescale 1ns / 1ps
// Shift-and-add multiplier: one multiplier bit per cycle, LSB first.
module skf_mul
  import skf_pkg::*;
#(
  parameter int AW = 33
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [AW-1:0]        mcand_i,
  input  gain_t                       mplier_i,
  output logic signed [AW+GAIN_W-1:0] prod_o,
  output logic                        done_o
);

  localparam int PW    = AW + GAIN_W;
  localparam int CNT_W = $clog2(GAIN_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(GAIN_W - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic signed [PW-1:0] mcand_q, mcand_d;
  logic signed [PW-1:0] acc_q, acc_d;
  gain_t                mplier_q, mplier_d;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    acc_d    = acc_q;
    mplier_d = mplier_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      mcand_d  = PW'(mcand_i);
      acc_d    = '0;
      mplier_d = mplier_i;
    end else if (busy_q) begin
      if (mplier_q[0]) acc_d = acc_q + mcand_q;
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
    mplier_q <= mplier_d;
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

/* rtl/skf_checker.sv */
`timescale 1ns / 1ps
`include "scalar_kalman_filter_unit_assert.svh"
module skf_checker
  import skf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_estimate,
  input logic [16:0] out_gain
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // The gain never exceeds one.
  `SKF_ASSERT_IMPL(a_gain_range, out_valid, out_gain <= GAIN_ONE)
  // One word in flight: no back-to-back samples.
  `SKF_ASSERT_NEXT(a_no_b2b, in_acc, !in_acc)
  // A result never appears right after a sample is taken.
  `SKF_ASSERT_NEXT(a_no_fast_result, in_acc, !$rose(out_valid))
  // Hold a stalled result word.
  `SKF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_estimate) && $stable(out_gain))

endmodule

bind scalar_kalman_filter_unit skf_checker u_skf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (meas_i.valid),
  .in_ready    (meas_i.ready),
  .out_valid   (result_o.valid),
  .out_ready   (result_o.ready),
  .out_estimate(result_o.filtered_estimate),
  .out_gain    (result_o.kalman_gain)
);

/* bench/scalar_kalman_filter_unit_test.sv */
`timescale 1ns / 1ps
module scalar_kalman_filter_unit_test;
  import skf_pkg::*;

  localparam int     FRAC_BITS    = 16;
  localparam int     SAMPLE_WIDTH = 16;
  localparam int     CYCLE_LIMIT  = 1_000_000;
  localparam int     TARGET_ITEMS = 400;
  localparam int     SETTLE_WAIT  = 40;   // a bit over the unit's latency
  localparam int     HOLD_CYCLES  = 400;
  localparam longint EST_HI       = 64'sd2147483647;
  localparam longint EST_LO       = -64'sd2147483648;
  localparam longint HALF_GAIN    = 64'sd1 <<< (GAIN_BITS - 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    est_t  estimate;
    gain_t gain;
  } filter_update_t;

  class kalman_tracker;
    est_t           est_q;
    var_t           var_q;
    var_t           q_reg;
    var_t           r_reg;
    filter_update_t pending_updates[$];
    int             errors;
    int             checked;
    int             zero_gain;
    int             unity_gain;

    function new();
      est_q      = '0;
      var_q      = var_t'(1) << FRAC_BITS;
      q_reg      = var_t'(20) << FRAC_BITS;
      r_reg      = var_t'(200) << FRAC_BITS;
      errors     = 0;
      checked    = 0;
      zero_gain  = 0;
      unity_gain = 0;
    endfunction

    function void set_noise(var_t q, var_t r);
      q_reg = q;
      r_reg = r;
    endfunction

    function int pending();
      return pending_updates.size();
    endfunction

    function longint clamp_est(longint v);
      if (v > EST_HI) return EST_HI;
      if (v < EST_LO) return EST_LO;
      return v;
    endfunction

    // Advance the filter state by one sample and queue the word it must produce.
    function void take_sample(sample_t m);
      logic [63:0]    pm;
      logic [63:0]    sum;
      logic [63:0]    k;
      logic [63:0]    pn;
      longint         z;
      longint         x;
      longint         d;
      longint         stp;
      longint         xn;
      filter_update_t upd;
      pm = {32'b0, var_q} + {32'b0, q_reg};
      if (pm > 64'hFFFF_FFFF) pm = 64'hFFFF_FFFF;
      sum = pm + {32'b0, r_reg};
      k = (sum == 0) ? 64'd0 : (pm << GAIN_BITS) / sum;
      if (k > 64'(GAIN_ONE)) k = 64'(GAIN_ONE);
      z   = clamp_est(longint'(m) <<< FRAC_BITS);
      x   = longint'(est_q);
      d   = z - x;
      stp = (d * longint'(k) + HALF_GAIN) >>> GAIN_BITS;
      xn  = clamp_est(x + stp);
      pn  = (pm * (64'(GAIN_ONE) - k)) >> GAIN_BITS;
      est_q = est_t'(xn[31:0]);
      var_q = pn[31:0];
      if (k == 0) zero_gain++;
      if (k == 64'(GAIN_ONE)) unity_gain++;
      upd.estimate = est_q;
      upd.gain     = k[GAIN_W-1:0];
      pending_updates.push_back(upd);
    endfunction

    function void check_update(est_t est, gain_t k);
      filter_update_t want;
      if (pending_updates.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result word est=%0d gain=%0d", est, k);
        return;
      end
      want = pending_updates.pop_front();
      checked++;
      if (est !== want.estimate || k !== want.gain) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d: est exp %0d got %0d, gain exp %0d got %0d",
                   checked, want.estimate, est, want.gain, k);
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  cfg_idx_e cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  skf_meas_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) meas_if ();
  skf_result_if result_if ();

  scalar_kalman_filter_unit #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .meas_i    (meas_if),
    .result_o  (result_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  kalman_tracker tracker = new();
  int  samples_sent = 0;
  int  noise_settings = 0;
  int  hold_at = 32'h7FFF_FFFF;
  int  cycle_count = 0;
  bit  busy_mode = 1'b0;
  bit  long_hold = 1'b0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int r;
    if (busy_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  function automatic var_t pick_noise(var_t typical_max);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      3:       return $urandom_range(0, 255);
      default: return $urandom_range(0, typical_max);
    endcase
  endfunction

  function automatic sample_t pick_sample(int level);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      v = level + int'($urandom_range(0, 512)) - 256;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return sample_t'(v);
    end
    if (r < 85) return sample_t'($urandom);
    case ($urandom_range(0, 3))
      0:       return sample_t'(-32768);
      1:       return sample_t'(32767);
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic send_sample(input sample_t m);
    meas_if.valid       <= 1'b1;
    meas_if.measurement <= m;
    do @(posedge clk_i); while (!meas_if.ready);
    tracker.take_sample(m);
    samples_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      meas_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every result, then let the datapath go quiet.
  task automatic settle();
    pause_sender(1);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_noise(input var_t q, input var_t r);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PROCESS_NOISE;
    cfg_data_i <= q;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MEASUREMENT_NOISE;
    cfg_data_i <= r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_noise(q, r);
    noise_settings++;
  endtask

  task automatic send_batch(input sample_t batch[$]);
    foreach (batch[i]) begin
      send_sample(batch[i]);
      pause_sender(pick_gap());
    end
  endtask

  // Result side: random stalls plus one long hold-off that backs up the input.
  initial begin : receiver
    int stall;
    stall = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold || stall > 0) begin
        result_if.ready <= 1'b0;
        if (stall > 0) stall--;
      end else begin
        stall = pick_gap();
        result_if.ready <= (stall == 0);
      end
    end
  end

  initial begin : backpressure
    wait (samples_sent >= hold_at);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready)
      tracker.check_update(result_if.filtered_estimate, result_if.kalman_gain);
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("scalar_kalman_filter_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    sample_t batch[$];
    int      level;
    int      n;
    rst_ni              = 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_PROCESS_NOISE;
    cfg_data_i          <= '0;
    meas_if.valid       <= 1'b0;
    meas_if.measurement <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset noise values: sample extremes, small values and alternating bit patterns.
    batch = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 16'sh5555, 16'shAAAA,
              16'sd100};
    send_batch(batch);

    // Both noise terms at full scale: prior variance saturates.
    settle();
    write_noise('1, '1);
    batch = '{16'sd32767, -16'sd32768, 16'sd0};
    send_batch(batch);

    // No noise at all: unity gain once, then a zero denominator.
    settle();
    write_noise('0, '0);
    batch = '{16'sd1234, -16'sd5, 16'sd77, 16'sd32767};
    send_batch(batch);

    // No measurement noise with saturating prior: sample taken as is.
    settle();
    write_noise('1, '0);
    batch = '{-16'sd32768, 16'sd32767};
    send_batch(batch);

    // Tiny process noise against huge measurement noise: gain near zero.
    settle();
    write_noise(32'd1, '1);
    batch = '{16'sd32767, -16'sd32768, 16'sd10};
    send_batch(batch);

    hold_at = samples_sent + 10;
    while (samples_sent < TARGET_ITEMS) begin
      settle();
      busy_mode <= ($urandom_range(0, 3) == 0);
      write_noise(pick_noise(32'h0010_0000), pick_noise(32'h0400_0000));
      n     = $urandom_range(30, 60);
      level = int'($urandom_range(0, 40000)) - 20000;
      repeat (n) begin
        level += int'($urandom_range(0, 200)) - 100;
        if (level > 32767) level = 32767;
        if (level < -32768) level = -32768;
        send_sample(pick_sample(level));
        pause_sender(pick_gap());
      end
    end

    settle();
    if (tracker.pending() != 0)
      $display("ERROR: %0d results never arrived", tracker.pending());
    $display("covered %0d samples over %0d noise settings, %0d results checked",
             samples_sent, noise_settings + 1, tracker.checked);
    $display("gain zero %0d times and exactly one %0d times, with a %0d-cycle output hold",
             tracker.zero_gain, tracker.unity_gain, HOLD_CYCLES);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("scalar_kalman_filter_unit regression: pass");
    else
      $display("scalar_kalman_filter_unit regression: fail");
    $finish;
  end

endmodule
